// File: src/tcbt_pkg.sv
`default_nettype none

package tcbt_pkg;

  localparam int FRAC_W        = 5;
  localparam int FACTOR_W      = 18;
  localparam int IO_POINT_W    = 32;
  localparam int POINT_W_DEF   = 32;
  localparam int STAGES        = 7;

  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd8;
  localparam logic [FRAC_W-1:0] FRAC_MIN   = 5'd1;
  localparam logic [FRAC_W-1:0] FRAC_MAX   = 5'd16;

  typedef logic [FRAC_W-1:0] frac_t;

  function automatic frac_t clamp_frac(input frac_t f);
    frac_t g;
    g = f;
    if (f < FRAC_MIN) begin
      g = FRAC_MIN;
    end else if (f > FRAC_MAX) begin
      g = FRAC_MAX;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// File: src/tcbt_datapath.sv
`default_nettype none

module tcbt_datapath
  import tcbt_pkg::*;
#(
  parameter int POINT_WIDTH = POINT_W_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire frac_t                          frac,
  input  wire logic                           op,
  input  wire logic signed [IO_POINT_W-1:0]   point_before,
  input  wire logic signed [IO_POINT_W-1:0]   point_current,
  input  wire logic signed [IO_POINT_W-1:0]   point_after,
  input  wire logic signed [FACTOR_W-1:0]     tension,
  input  wire logic signed [FACTOR_W-1:0]     continuity,
  input  wire logic signed [FACTOR_W-1:0]     bias,
  output logic signed [IO_POINT_W-1:0]        tangent
);

  localparam int P   = POINT_WIDTH;
  localparam int FW  = FACTOR_W + 1;
  localparam int M1W = P + FW;
  localparam int M3W = P + FACTOR_W;
  localparam int SW  = P + 16;
  localparam int PW  = SW + FW;

  // Stage 1: chord differences and factor terms.
  logic signed [P-1:0]        pb, pc, pa;
  logic signed [FW-1:0]       one, bias_x, ten_x;
  logic signed [FACTOR_W-1:0] half, con_half;
  logic signed [P-1:0]        d1_r, d1_nxt, d2_r, d2_nxt;
  logic signed [FW-1:0]       opb_r, opb_nxt, omb_r, omb_nxt, omt_r, omt_nxt;
  logic signed [FACTOR_W-1:0] wgt_r, wgt_nxt;

  always_comb begin
    pa       = $signed(point_before[P-1:0]);
    pb       = $signed(point_current[P-1:0]);
    pc       = $signed(point_after[P-1:0]);
    one      = $signed(FW'(1) << frac);
    bias_x   = FW'(bias);
    ten_x    = FW'(tension);
    half     = $signed(FACTOR_W'(1) << (frac - FRAC_W'(1)));
    con_half = continuity >>> 1;
    d1_nxt   = pb - pa;
    d2_nxt   = pc - pb;
    opb_nxt  = one + bias_x;
    omb_nxt  = one - bias_x;
    omt_nxt  = one - ten_x;
    wgt_nxt  = op ? (half - con_half) : (half + con_half);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= d1_nxt;
      d2_r  <= d2_nxt;
      opb_r <= opb_nxt;
      omb_r <= omb_nxt;
      omt_r <= omt_nxt;
      wgt_r <= wgt_nxt;
    end
  end

  // Stage 2: weighted chord products.
  logic signed [M1W-1:0]      m1_r, m2_r;
  logic signed [FACTOR_W-1:0] wgt2_r;
  logic signed [FW-1:0]       omt2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= d1_r * opb_r;
      m2_r   <= d2_r * omb_r;
      wgt2_r <= wgt_r;
      omt2_r <= omt_r;
    end
  end

  // Stage 3: scale down, wrap, chord difference.
  logic signed [M1W-1:0]      sh1, sh2;
  logic signed [P-1:0]        h_nxt, t_nxt;
  logic signed [P-1:0]        h3_r, t3_r;
  logic signed [FACTOR_W-1:0] wgt3_r;
  logic signed [FW-1:0]       omt3_r;

  always_comb begin
    sh1   = m1_r >>> frac;
    sh2   = m2_r >>> frac;
    h_nxt = $signed(sh1[P-1:0]);
    t_nxt = $signed(sh2[P-1:0]) - h_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h3_r   <= h_nxt;
      t3_r   <= t_nxt;
      wgt3_r <= wgt2_r;
      omt3_r <= omt2_r;
    end
  end

  // Stage 4: continuity blend product.
  logic signed [M3W-1:0] m3_r;
  logic signed [P-1:0]   h4_r;
  logic signed [FW-1:0]  omt4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r   <= t3_r * wgt3_r;
      h4_r   <= h3_r;
      omt4_r <= omt3_r;
    end
  end

  // Stage 5: scale down and add the first product back.
  logic signed [M3W-1:0] j_sh, sum_full;
  logic signed [SW-1:0]  s5_r;
  logic signed [FW-1:0]  omt5_r;

  always_comb begin
    j_sh     = m3_r >>> frac;
    sum_full = j_sh + M3W'(h4_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r   <= $signed(sum_full[SW-1:0]);
      omt5_r <= omt4_r;
    end
  end

  // Stage 6: tension product.
  logic signed [PW-1:0] p6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p6_r <= s5_r * omt5_r;
    end
  end

  // Stage 7: final scaling and output register.
  logic [PW-1:0]                pr_sh;
  logic signed [IO_POINT_W-1:0] tangent_r, tangent_nxt;

  always_comb begin
    pr_sh       = $unsigned(p6_r) >> frac;
    tangent_nxt = IO_POINT_W'($signed(pr_sh[P-1:0]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tangent_r <= tangent_nxt;
    end
  end

  assign tangent = tangent_r;

endmodule

`default_nettype wire

// File: src/tcb_spline_tangent.sv
`default_nettype none
// Kochanek-Bartels tangent unit, seven register stages deep.
// An accepted item moves through the stage registers in order and is valid at the output after the last one.
// Throughput: one item per cycle; the pipeline advances whenever the output is free.
// A stall on the output holds every stage in place while the output stage holds a valid item.
// Reset clears all stage valid bits and sets frac_r to 8.

module tcb_spline_tangent
  import tcbt_pkg::*;
#(
  parameter int POINT_WIDTH = POINT_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [FRAC_W-1:0]            cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_op,
  input  wire logic signed [IO_POINT_W-1:0] in_point_before,
  input  wire logic signed [IO_POINT_W-1:0] in_point_current,
  input  wire logic signed [IO_POINT_W-1:0] in_point_after,
  input  wire logic signed [FACTOR_W-1:0]   in_tension,
  input  wire logic signed [FACTOR_W-1:0]   in_continuity,
  input  wire logic signed [FACTOR_W-1:0]   in_bias,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [IO_POINT_W-1:0]      out_tangent
);

  frac_t              frac_r;
  frac_t              frac_g;
  logic [STAGES-1:0]  valid_r, valid_nxt;
  logic               advance;

  assign advance   = !valid_r[STAGES-1] || !out_stall;
  assign in_stall  = !advance;
  assign frac_g    = clamp_frac(frac_r);
  assign valid_nxt = {valid_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RESET;
    end else if (cfg_we) begin
      frac_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
    end
  end

  tcbt_datapath #(
    .POINT_WIDTH (POINT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .en            (advance),
    .frac          (frac_g),
    .op            (in_op),
    .point_before  (in_point_before),
    .point_current (in_point_current),
    .point_after   (in_point_after),
    .tension       (in_tension),
    .continuity    (in_continuity),
    .bias          (in_bias),
    .tangent       (out_tangent)
  );

  assign out_valid = valid_r[STAGES-1];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> valid_r[0])
    else $error("accepted item did not enter the first stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output was free");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && valid_r[0]) |=> valid_r[0])
    else $error("first stage lost its item under stall");

  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && valid_r[STAGES-2]) |=> out_valid)
    else $error("item did not reach the output stage");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
  import tcbt_pkg::*;

  typedef struct {
    logic                         op;
    logic signed [IO_POINT_W-1:0] prior;
    logic signed [IO_POINT_W-1:0] current;
    logic signed [IO_POINT_W-1:0] after;
    logic signed [FACTOR_W-1:0]   tension;
    logic signed [FACTOR_W-1:0]   continuity;
    logic signed [FACTOR_W-1:0]   bias;
  } key_set_t;

  class tangent_scoreboard;
    logic signed [IO_POINT_W-1:0] tangent_q[$];
    int frac_bits;
    int errors;

    function new();
      frac_bits = FRAC_RESET;
      errors = 0;
    endfunction

    function void set_fraction(int v);
      frac_bits = v;
    endfunction

    function logic signed [IO_POINT_W-1:0] tangent_of(key_set_t k);
      int g;
      longint one, d1, d2, first, second, diff, wgt, blend, scaled;
      longint ten, con, bia;
      longint unsigned prod;
      logic signed [IO_POINT_W-1:0] w;
      g = frac_bits;
      if (g < 1) begin
        g = 1;
      end
      if (g > 16) begin
        g = 16;
      end
      one = longint'(1) << g;
      ten = k.tension;
      con = k.continuity;
      bia = k.bias;
      w = k.current - k.prior;
      d1 = w;
      w = k.after - k.current;
      d2 = w;
      scaled = (d1 * (one + bia)) >>> g;
      w = scaled[IO_POINT_W-1:0];
      first = w;
      second = (d2 * (one - bia)) >>> g;
      scaled = second - first;
      w = scaled[IO_POINT_W-1:0];
      diff = w;
      if (k.op) begin
        wgt = (longint'(1) << (g - 1)) - (con >>> 1);
      end else begin
        wgt = (longint'(1) << (g - 1)) + (con >>> 1);
      end
      blend = (diff * wgt) >>> g;
      prod = (blend + first) * (one - ten);
      prod = prod >> g;
      return prod[IO_POINT_W-1:0];
    endfunction

    function void note_keys(key_set_t k);
      tangent_q.push_back(tangent_of(k));
    endfunction

    function void check_tangent(logic signed [IO_POINT_W-1:0] actual);
      logic signed [IO_POINT_W-1:0] want;
      if (tangent_q.size() == 0) begin
        errors++;
        if (errors <= 50) begin
          $display("%0t: tangent mismatch: expected none, got %0d", $time, actual);
        end
      end else begin
        want = tangent_q.pop_front();
        if (want !== actual) begin
          errors++;
          if (errors <= 50) begin
            $display("%0t: tangent mismatch: expected %0d, got %0d", $time, want, actual);
          end
        end
      end
    endfunction

    function int pending();
      return tangent_q.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [FRAC_W-1:0]            cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_op;
  logic signed [IO_POINT_W-1:0] in_point_before;
  logic signed [IO_POINT_W-1:0] in_point_current;
  logic signed [IO_POINT_W-1:0] in_point_after;
  logic signed [FACTOR_W-1:0]   in_tension;
  logic signed [FACTOR_W-1:0]   in_continuity;
  logic signed [FACTOR_W-1:0]   in_bias;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [IO_POINT_W-1:0] out_tangent;

  tangent_scoreboard sb = new();
  key_set_t seen;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int eff_frac = 8;
  int phase_fracs[8];

  tcb_spline_tangent DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_point_before  (in_point_before),
    .in_point_current (in_point_current),
    .in_point_after   (in_point_after),
    .in_tension       (in_tension),
    .in_continuity    (in_continuity),
    .in_bias          (in_bias),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tangent      (out_tangent)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("** tcb_spline_tangent: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.set_fraction(cfg_wdata);
      end
      if (in_valid && !in_stall) begin
        seen.op = in_op;
        seen.prior = in_point_before;
        seen.current = in_point_current;
        seen.after = in_point_after;
        seen.tension = in_tension;
        seen.continuity = in_continuity;
        seen.bias = in_bias;
        sb.note_keys(seen);
      end
      if (out_valid && !out_stall) begin
        sb.check_tangent(out_tangent);
      end
    end
  end

  initial begin
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end else if (r < 55) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 95) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end
    end
  end

  function automatic key_set_t make_keys(logic o, logic signed [IO_POINT_W-1:0] b,
                                         logic signed [IO_POINT_W-1:0] c,
                                         logic signed [IO_POINT_W-1:0] a,
                                         logic signed [FACTOR_W-1:0] t,
                                         logic signed [FACTOR_W-1:0] cn,
                                         logic signed [FACTOR_W-1:0] bi);
    key_set_t k;
    k.op = o;
    k.prior = b;
    k.current = c;
    k.after = a;
    k.tension = t;
    k.continuity = cn;
    k.bias = bi;
    return k;
  endfunction

  function automatic logic signed [IO_POINT_W-1:0] edge_point();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic signed [FACTOR_W-1:0] rand_factor(int g);
    int v;
    int unit;
    unit = 1 << g;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 2 * unit)) - unit;
      4, 5, 6: v = int'($urandom_range(0, 131072)) - 65536;
      7, 8: v = $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0: v = -131072;
          1: v = 131071;
          2: v = 65536;
          3: v = -65536;
          4: v = 0;
          5: v = unit;
          default: v = -unit;
        endcase
      end
    endcase
    return v[FACTOR_W-1:0];
  endfunction

  function automatic key_set_t rand_keys(int g);
    key_set_t k;
    logic signed [IO_POINT_W-1:0] base;
    int step;
    k.op = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: begin
        k.prior = $urandom;
        k.current = $urandom;
        k.after = $urandom;
      end
      1: begin
        base = $urandom;
        step = int'($urandom_range(0, 8191)) - 4096;
        k.prior = base - step;
        k.current = base;
        step = int'($urandom_range(0, 8191)) - 4096;
        k.after = base + step;
      end
      2: begin
        k.prior = edge_point();
        k.current = edge_point();
        k.after = edge_point();
      end
      default: begin
        k.prior = int'($urandom_range(0, 2000)) - 1000;
        k.current = int'($urandom_range(0, 2000)) - 1000;
        k.after = int'($urandom_range(0, 2000)) - 1000;
      end
    endcase
    k.tension = rand_factor(g);
    k.continuity = rand_factor(g);
    k.bias = rand_factor(g);
    return k;
  endfunction

  function automatic int pick_gap(bit dense);
    int r;
    r = $urandom_range(0, 99);
    if (r < (dense ? 85 : 45)) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic offer_keys(key_set_t k, bit dense);
    int gap;
    in_valid <= 1'b1;
    in_op <= k.op;
    in_point_before <= k.prior;
    in_point_current <= k.current;
    in_point_after <= k.after;
    in_tension <= k.tension;
    in_continuity <= k.continuity;
    in_bias <= k.bias;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap(dense);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_fraction(int v);
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[FRAC_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_frac = (v < 1) ? 1 : (v > 16) ? 16 : v;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_op <= 1'b0;
    in_point_before <= '0;
    in_point_current <= '0;
    in_point_after <= '0;
    in_tension <= '0;
    in_continuity <= '0;
    in_bias <= '0;
    phase_fracs = '{16, 1, 0, 31, 17, 4, 0, 8};
    phase_fracs[6] = $urandom_range(0, 31);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_keys(make_keys(0, 0, 0, 0, 0, 0, 0), 0);
    offer_keys(make_keys(1, 0, 0, 0, 0, 0, 0), 0);
    offer_keys(make_keys(0, 100, 200, 400, 0, 0, 0), 0);
    offer_keys(make_keys(1, 100, 200, 400, 0, 0, 0), 0);
    offer_keys(make_keys(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0), 0);
    offer_keys(make_keys(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 128, -128, 64), 0);
    offer_keys(make_keys(0, 0, -1, -3, 0, 0, 3), 0);
    offer_keys(make_keys(1, 5, -7, 11, -1, 1, -1), 0);
    offer_keys(make_keys(0, 1000, -2000, 3000, -131072, 131071, 131071), 0);
    offer_keys(make_keys(1, -1000, 2000, -3000, 131071, -131072, -131072), 0);
    offer_keys(make_keys(0, 12345, 54321, -777, 65536, 65536, -65536), 0);
    offer_keys(make_keys(1, 12345, 54321, -777, -65536, -65536, 65536), 0);
    offer_keys(make_keys(0, 1, 1000, 5000, 256, 0, 0), 0);
    offer_keys(make_keys(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                         -131072, 131071, -131072), 0);
    offer_keys(make_keys(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         -65536, -131072, 131071), 0);
    offer_keys(make_keys(0, -1, -1, -1, 0, 0, 0), 0);
    in_valid <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      write_fraction(phase_fracs[p]);
      for (int n = 0; n < 75; n++) begin
        if (p == 2 && n == 10) begin
          hold_request = 1'b1;
        end
        offer_keys(rand_keys(eff_frac), p % 2 == 1);
      end
      in_valid <= 1'b0;
    end

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** tcb_spline_tangent: PASSED **");
    end else begin
      $display("** tcb_spline_tangent: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/tcbt_pkg.sv
src/tcbt_datapath.sv
src/tcb_spline_tangent.sv
verif/testbench.sv
